@@ hdl/sis_pkg.sv @@
// Shared types and constants for the stable insertion sorter.
package sis_pkg;

  // Default sizing
  localparam int unsigned CapacityDef = 32;
  localparam int unsigned KeyBitsDef  = 16;

  // Field widths of the words on the ports
  localparam int unsigned KeyW    = 16;
  localparam int unsigned TagW    = 16;
  localparam int unsigned KeyMaxW = 32;

  // Input word
  typedef struct packed {
    logic signed [KeyW-1:0] sort_key;
    logic [TagW-1:0]        entry_tag;
    logic                   set_end;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [KeyW-1:0] out_key;
    logic [TagW-1:0]        out_tag;
    logic                   run_last;
    logic                   overflowed;
  } out_word_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast pair this cycle
    logic drain;  // shift the whole row one cell towards the head
  } cell_ctrl_t;

endpackage

@@ hdl/sis_cell.sv @@
// One compare-and-shift cell of the sorting row.
module sis_cell #(
  parameter int unsigned KEY_BITS = sis_pkg::KeyBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sis_pkg::cell_ctrl_t      ctrl_i,
  input  logic [KEY_BITS-1:0]      new_key_i,
  input  logic [sis_pkg::TagW-1:0] new_tag_i,
  // neighbour towards the head
  input  logic                     prev_occ_i,
  input  logic                     prev_gt_i,
  input  logic [KEY_BITS-1:0]      prev_key_i,
  input  logic [sis_pkg::TagW-1:0] prev_tag_i,
  // neighbour towards the tail
  input  logic                     next_occ_i,
  input  logic [KEY_BITS-1:0]      next_key_i,
  input  logic [sis_pkg::TagW-1:0] next_tag_i,
  // own state
  output logic                     occ_o,
  output logic                     gt_o,
  output logic [KEY_BITS-1:0]      key_o,
  output logic [sis_pkg::TagW-1:0] tag_o
);

  logic                     occ_q, occ_d;
  logic [KEY_BITS-1:0]      key_q, key_d;
  logic [sis_pkg::TagW-1:0] tag_q, tag_d;

  // strictly greater only, so equal keys stay put
  assign gt_o = occ_q && ($signed(key_q) > $signed(new_key_i));

  // next state: drain shifts down, insert shifts up or takes the new pair
  always_comb begin
    occ_d = occ_q;
    key_d = key_q;
    tag_d = tag_q;
    if (ctrl_i.drain) begin
      occ_d = next_occ_i;
      key_d = next_key_i;
      tag_d = next_tag_i;
    end else if (ctrl_i.ins) begin
      if (prev_gt_i) begin
        occ_d = 1'b1;
        key_d = prev_key_i;
        tag_d = prev_tag_i;
      end else if (gt_o || (!occ_q && prev_occ_i)) begin
        occ_d = 1'b1;
        key_d = new_key_i;
        tag_d = new_tag_i;
      end
    end
  end

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign occ_o = occ_q;
  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

@@ hdl/stable_insertion_sorter_core.sv @@
// Stable insertion sorter: a row of compare-and-shift cells with a drain sequencer.
// Loading: one pair per cycle while busy is low; every cell compares against the broadcast key in parallel.
// Output: the first result appears the cycle after the set_end word is taken, then one
// result per cycle; busy stays high for the whole run, and start is taken
// again in the cycle after the final result. Results cannot be stalled.
// Reset (rst_ni low, asynchronous) empties the row and clears the overflow flag.
module stable_insertion_sorter_core #(
  parameter int unsigned CAPACITY = sis_pkg::CapacityDef,
  parameter int unsigned KEY_BITS = sis_pkg::KeyBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  sis_pkg::in_word_t  item_i,
  output logic               busy,
  output sis_pkg::out_word_t result_o,
  output logic               result_valid_o
);

  logic                     accept;
  logic                     full;
  logic                     drain_q, drain_d;
  logic                     ovf_q, ovf_d;
  sis_pkg::cell_ctrl_t      ctrl;
  logic [KEY_BITS-1:0]      in_key;
  logic [sis_pkg::KeyMaxW-1:0] in_key_wide;
  logic [sis_pkg::KeyMaxW-1:0] out_key_wide;

  logic [CAPACITY-1:0]      occ;
  logic [CAPACITY-1:0]      gt;
  logic [KEY_BITS-1:0]      keys [CAPACITY];
  logic [sis_pkg::TagW-1:0] tags [CAPACITY];

  // word accepted; a full row drops the pair
  assign accept = start && !busy;
  assign full   = occ[CAPACITY-1];

  // key resized to the internal width; upper bits beyond KEY_BITS ignored
  assign in_key_wide = sis_pkg::KeyMaxW'(item_i.sort_key);
  assign in_key      = in_key_wide[KEY_BITS-1:0];

  assign ctrl.ins   = accept && !full;
  assign ctrl.drain = drain_q;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     p_occ, p_gt, n_occ;
    logic [KEY_BITS-1:0]      p_key, n_key;
    logic [sis_pkg::TagW-1:0] p_tag, n_tag;

    if (i == 0) begin : g_head
      assign p_occ = 1'b1;
      assign p_gt  = 1'b0;
      assign p_key = in_key;
      assign p_tag = item_i.entry_tag;
    end else begin : g_body
      assign p_occ = occ[i-1];
      assign p_gt  = gt[i-1];
      assign p_key = keys[i-1];
      assign p_tag = tags[i-1];
    end

    if (i == CAPACITY-1) begin : g_tail
      assign n_occ = 1'b0;
      assign n_key = keys[i];
      assign n_tag = tags[i];
    end else begin : g_mid
      assign n_occ = occ[i+1];
      assign n_key = keys[i+1];
      assign n_tag = tags[i+1];
    end

    sis_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_key_i (in_key),
      .new_tag_i (item_i.entry_tag),
      .prev_occ_i(p_occ),
      .prev_gt_i (p_gt),
      .prev_key_i(p_key),
      .prev_tag_i(p_tag),
      .next_occ_i(n_occ),
      .next_key_i(n_key),
      .next_tag_i(n_tag),
      .occ_o     (occ[i]),
      .gt_o      (gt[i]),
      .key_o     (keys[i]),
      .tag_o     (tags[i])
    );
  end

  // sequencer: drain from the set_end word until the head is the last entry
  always_comb begin
    drain_d = drain_q;
    ovf_d   = ovf_q;
    if (drain_q) begin
      if (!occ[1]) begin
        drain_d = 1'b0;
        ovf_d   = 1'b0;
      end
    end else if (accept) begin
      ovf_d = ovf_q | full;
      if (item_i.set_end) begin
        drain_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
    end
  end

  // result word straight from the head cell
  assign out_key_wide        = sis_pkg::KeyMaxW'(keys[0]);
  assign busy                = drain_q;
  assign result_valid_o      = drain_q;
  assign result_o.out_key    = out_key_wide[sis_pkg::KeyW-1:0];
  assign result_o.out_tag    = tags[0];
  assign result_o.run_last   = !occ[1];
  assign result_o.overflowed = ovf_q;

  // a result is only ever taken from an occupied head cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> occ[0])
    else $error("result emitted from empty head cell");

  // the final result of a run frees the block in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.run_last) |=> (!busy && occ == '0))
    else $error("row not empty after final result");

  // a taken set_end word starts the run in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.set_end) |=> result_valid_o)
    else $error("run did not start after set_end");

  // occupied cells always form an unbroken prefix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ & ~{occ[CAPACITY-2:0], 1'b1}) == '0)
    else $error("gap in occupied cells");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the stable insertion sorter core.
module tb;

  localparam int unsigned Cap = sis_pkg::CapacityDef;

  // Pending input word with its pacing
  typedef struct {
    sis_pkg::in_word_t word;
    int                gap;
    bit                drain;
  } pending_t;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               start     = 1'b0;
  sis_pkg::in_word_t  in_word   = '0;
  logic               busy;
  sis_pkg::out_word_t res_word;
  logic               res_valid;

  pending_t           pending[$];
  sis_pkg::out_word_t sorted_run[$];
  int                 errors    = 0;

  // Driver state
  pending_t  staged_w;
  bit        staged    = 1'b0;
  bit        presented = 1'b0;
  int        gap_left  = 0;
  bit        go;

  // Predictor state: sorted cells, fill level, overflow flag
  logic signed [sis_pkg::KeyW-1:0] row_key[Cap];
  logic [sis_pkg::TagW-1:0]        row_tag[Cap];
  int                              row_fill = 0;
  bit                              row_ovf  = 1'b0;

  sis_pkg::out_word_t want_w;

  stable_insertion_sorter_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (in_word),
    .busy           (busy),
    .result_o       (res_word),
    .result_valid_o (res_valid)
  );

  always #5 clk_i = ~clk_i;

  // Insert a taken word if room is left; on set end, queue the whole run
  task automatic sort_insert(input sis_pkg::in_word_t w);
    int pos;
    sis_pkg::out_word_t r;
    if (row_fill >= Cap) begin
      row_ovf = 1'b1;
    end else begin
      pos = row_fill;
      while (pos > 0 && row_key[pos-1] > w.sort_key) begin
        row_key[pos] = row_key[pos-1];
        row_tag[pos] = row_tag[pos-1];
        pos--;
      end
      row_key[pos] = w.sort_key;
      row_tag[pos] = w.entry_tag;
      row_fill++;
    end
    if (w.set_end) begin
      for (int i = 0; i < row_fill; i++) begin
        r.out_key    = row_key[i];
        r.out_tag    = row_tag[i];
        r.run_last   = (i == row_fill - 1);
        r.overflowed = row_ovf;
        sorted_run   = {sorted_run, r};
      end
      row_fill = 0;
      row_ovf  = 1'b0;
    end
  endtask

  // Mostly short gaps, a few long ones; no gaps when quiet
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_pair(input int key, input int tag, input bit last,
                            input int gap, input bit drain);
    pending_t p;
    p.word.sort_key  = key[sis_pkg::KeyW-1:0];
    p.word.entry_tag = tag[sis_pkg::TagW-1:0];
    p.word.set_end   = last;
    p.gap            = gap;
    p.drain          = drain;
    pending          = {pending, p};
  endtask

  // Driver: present staged words, hold start until taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sort_insert(in_word);
        presented = 1'b0;
      end
      if (!presented) begin
        go = 1'b0;
        if (!staged && pending.size() > 0) begin
          staged_w = pending.pop_front();
          staged   = 1'b1;
          gap_left = staged_w.gap;
        end
        if (staged && gap_left > 0) begin
          gap_left--;
        end else if (staged && (!staged_w.drain || sorted_run.size() == 0)) begin
          go        = 1'b1;
          staged    = 1'b0;
          presented = 1'b1;
          in_word  <= staged_w.word;
        end
        start <= go;
      end
    end
  end

  // Monitor: every result word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_valid) begin
      if (sorted_run.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time, res_word);
        errors++;
      end else begin
        want_w = sorted_run.pop_front();
        if (res_word.out_key !== want_w.out_key) begin
          $display("%0t: out_key expected %0d actual %0d", $time,
                   want_w.out_key, res_word.out_key);
          errors++;
        end
        if (res_word.out_tag !== want_w.out_tag) begin
          $display("%0t: out_tag expected %h actual %h", $time,
                   want_w.out_tag, res_word.out_tag);
          errors++;
        end
        if (res_word.run_last !== want_w.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time,
                   want_w.run_last, res_word.run_last);
          errors++;
        end
        if (res_word.overflowed !== want_w.overflowed) begin
          $display("%0t: overflowed expected %b actual %b", $time,
                   want_w.overflowed, res_word.overflowed);
          errors++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int count;
    int set_no;
    int size;
    int r;
    bit narrow;
    bit quiet;
    int key;

    // Single-word set at the most negative key, all-ones tag
    queue_pair(-32768, 16'hFFFF, 1'b1, 0, 1'b0);
    // Key extremes with a tie on zero
    queue_pair(32767, 1, 1'b0, 0, 1'b0);
    queue_pair(-32768, 2, 1'b0, 1, 1'b0);
    queue_pair(0, 3, 1'b0, 0, 1'b0);
    queue_pair(-1, 4, 1'b0, 0, 1'b0);
    queue_pair(0, 5, 1'b1, 0, 1'b0);
    // Equal keys keep arrival order
    queue_pair(7, 16'h0000, 1'b0, 0, 1'b0);
    queue_pair(7, 16'h0011, 1'b0, 0, 1'b0);
    queue_pair(7, 16'h0022, 1'b0, 0, 1'b0);
    queue_pair(7, 16'h0033, 1'b1, 0, 1'b0);
    // Strictly descending set; the sender waits for every result first
    queue_pair(3, 16'hA000, 1'b0, 0, 1'b1);
    queue_pair(2, 16'hA001, 1'b0, 0, 1'b0);
    queue_pair(1, 16'hA002, 1'b0, 0, 1'b0);
    queue_pair(0, 16'hA003, 1'b1, 0, 1'b0);
    count = 14;

    // Random sets: first a full row, then one whose end word is dropped
    set_no = 0;
    while (count < 280) begin
      r = $urandom_range(0, 99);
      if (set_no == 0)   size = Cap;
      else if (set_no == 1) size = Cap + 1;
      else if (r < 70)   size = $urandom_range(1, 8);
      else if (r < 93)   size = $urandom_range(9, Cap);
      else               size = $urandom_range(Cap + 1, Cap + 8);
      narrow = ($urandom_range(0, 1) == 1);
      quiet  = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < size; i++) begin
        key = narrow ? $urandom_range(0, 7) - 4 : $urandom_range(0, 65535);
        queue_pair(key, $urandom_range(0, 65535), i == size - 1, pick_gap(quiet),
                   i == 0 && $urandom_range(0, 7) == 0);
      end
      count += size;
      set_no++;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() > 0 || staged || presented || sorted_run.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
